// File: hw/rtl/ipv4ae_pkg.sv
// Package with character codes, token state type and token scan functions.
`default_nettype none

package ipv4ae_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] OCTET_MAX    = 16'd255;
  localparam logic [15:0] PORT_MAX     = 16'd65535;
  localparam logic [2:0]  OCTET_DIGITS = 3'd3;
  localparam logic [2:0]  PORT_DIGITS  = 3'd5;
  localparam logic [2:0]  OCTETS_BEFORE_LAST = 3'd3;
  localparam logic [2:0]  OCTETS_ALL   = 3'd4;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PLAIN = 2'd1;
  localparam logic [1:0] KIND_PORT  = 2'd2;

  typedef struct packed {
    logic        in_token;
    logic        token_bad;
    logic [2:0]  octet_index;
    logic [15:0] field_value;
    logic [2:0]  digit_count;
    logic        in_port_part;
    logic [31:0] octet_store;
  } tok_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] addr_port;
  } close_t;

  localparam tok_t TOK_CLEAR = '0;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic close_t close_token(tok_t t);
    close_t r;
    r = '0;
    if (t.in_token && !t.token_bad) begin
      if (t.in_port_part) begin
        if (t.digit_count != 3'd0) begin
          r.kind = KIND_PORT;
          r.addr_port = {t.octet_store, t.field_value};
        end
      end else if (t.octet_index == OCTETS_BEFORE_LAST && t.digit_count != 3'd0) begin
        r.kind = KIND_PLAIN;
        r.addr_port = {t.octet_store[23:0], t.field_value[7:0], 16'h0000};
      end
    end
    return r;
  endfunction

  function automatic tok_t scan_char(tok_t t, logic [7:0] c);
    tok_t        r;
    logic [19:0] prod;
    logic [2:0]  lim_digits;
    logic [15:0] lim_value;
    r = t;
    if (!r.in_token) begin
      r = TOK_CLEAR;
      r.in_token = 1'b1;
    end
    lim_digits = r.in_port_part ? PORT_DIGITS : OCTET_DIGITS;
    lim_value  = r.in_port_part ? PORT_MAX : OCTET_MAX;
    prod = ({4'b0, r.field_value} * 20'd10) + {16'b0, c[3:0]};
    if (!r.token_bad) begin
      if (is_digit(c)) begin
        if (r.digit_count == 3'd1 && r.field_value == 16'd0) begin
          r.token_bad = 1'b1;
        end else if (r.digit_count >= lim_digits) begin
          r.token_bad = 1'b1;
        end else if (prod > {4'b0, lim_value}) begin
          r.token_bad = 1'b1;
        end else begin
          r.field_value = prod[15:0];
          r.digit_count = r.digit_count + 3'd1;
        end
      end else if (c == CH_DOT) begin
        if (r.in_port_part || r.digit_count == 3'd0 ||
            r.octet_index >= OCTETS_BEFORE_LAST) begin
          r.token_bad = 1'b1;
        end else begin
          r.octet_store = {r.octet_store[23:0], r.field_value[7:0]};
          r.octet_index = r.octet_index + 3'd1;
          r.field_value = 16'd0;
          r.digit_count = 3'd0;
        end
      end else begin
        if (r.in_port_part || r.octet_index != OCTETS_BEFORE_LAST ||
            r.digit_count == 3'd0) begin
          r.token_bad = 1'b1;
        end else begin
          r.octet_store  = {r.octet_store[23:0], r.field_value[7:0]};
          r.octet_index  = OCTETS_ALL;
          r.field_value  = 16'd0;
          r.digit_count  = 3'd0;
          r.in_port_part = 1'b1;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipv4_address_extractor.sv
// Top level of the IPv4 address and port extractor for a byte stream of text lines.
// The result of a line is loaded into the output registers when its last byte is taken and shows in the cycle after it.
// Throughput: one byte per cycle; a new byte is taken while a result waits unless out is stalled.
// Reset: rst clears the token, pending and accepted match and output valid; output payload registers are not reset.
// Each line end clears the scan state so the next line starts fresh.
`default_nettype none

module ipv4_address_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  ch,
  input  wire logic        line_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [31:0]      address,
  output logic             has_port,
  output logic [15:0]      port
);

  ipv4ae_pkg::tok_t tok;
  ipv4ae_pkg::tok_t tok_next;
  logic             pending_valid;
  logic             pending_valid_next;
  logic [47:0]      pending_match;
  logic [47:0]      pending_match_next;
  logic             match_done;
  logic             match_done_next;
  logic [48:0]      match_result;
  logic [48:0]      match_result_next;

  logic             line_found;
  logic [48:0]      line_result;
  logic             in_take;
  logic             is_dig;
  logic             is_tok;
  logic             is_ws;

  ipv4ae_pkg::close_t close_mid;
  ipv4ae_pkg::close_t close_end;

  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign is_dig = ipv4ae_pkg::is_digit(ch);
  assign is_tok = is_dig || ch == ipv4ae_pkg::CH_DOT || ch == ipv4ae_pkg::CH_COLON;
  assign is_ws  = ch == ipv4ae_pkg::CH_SPACE || ch == ipv4ae_pkg::CH_TAB ||
                  ch == ipv4ae_pkg::CH_LF || ch == ipv4ae_pkg::CH_CR;

  assign close_mid = ipv4ae_pkg::close_token(tok);
  assign close_end = ipv4ae_pkg::close_token(tok_next);

  always_comb begin
    tok_next           = tok;
    pending_valid_next = pending_valid;
    pending_match_next = pending_match;
    match_done_next    = match_done;
    match_result_next  = match_result;
    if (!match_done) begin
      if (!is_tok && tok.in_token) begin
        tok_next = ipv4ae_pkg::TOK_CLEAR;
        if (close_mid.kind == ipv4ae_pkg::KIND_PLAIN && !pending_valid) begin
          match_done_next    = 1'b1;
          match_result_next  = {1'b0, close_mid.addr_port};
          pending_valid_next = 1'b0;
        end else if (close_mid.kind == ipv4ae_pkg::KIND_PORT && !pending_valid) begin
          pending_valid_next = 1'b1;
          pending_match_next = close_mid.addr_port;
        end
      end
      if (!match_done_next && pending_valid_next) begin
        if (is_ws) begin
          match_done_next    = 1'b1;
          match_result_next  = {1'b1, pending_match_next};
          pending_valid_next = 1'b0;
        end else if (is_dig) begin
          pending_valid_next = 1'b0;
        end
      end
      if (!match_done_next && is_tok) begin
        tok_next = ipv4ae_pkg::scan_char(tok_next, ch);
      end
    end
  end

  always_comb begin
    line_found  = match_done_next;
    line_result = match_result_next;
    if (!match_done_next) begin
      if (pending_valid_next) begin
        line_found  = 1'b1;
        line_result = {1'b1, pending_match_next};
      end else if (close_end.kind != ipv4ae_pkg::KIND_NONE) begin
        line_found  = 1'b1;
        line_result = {close_end.kind == ipv4ae_pkg::KIND_PORT, close_end.addr_port};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok           <= ipv4ae_pkg::TOK_CLEAR;
      pending_valid <= 1'b0;
      pending_match <= 48'd0;
      match_done    <= 1'b0;
      match_result  <= 49'd0;
    end else if (in_take) begin
      if (line_end) begin
        tok           <= ipv4ae_pkg::TOK_CLEAR;
        pending_valid <= 1'b0;
        pending_match <= 48'd0;
        match_done    <= 1'b0;
        match_result  <= 49'd0;
      end else begin
        tok           <= tok_next;
        pending_valid <= pending_valid_next;
        pending_match <= pending_match_next;
        match_done    <= match_done_next;
        match_result  <= match_result_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && line_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && line_end) begin
      found    <= line_found;
      address  <= line_found ? line_result[47:16] : 32'd0;
      has_port <= line_found ? line_result[48] : 1'b0;
      port     <= line_found ? line_result[15:0] : 16'd0;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst) !(pending_valid && match_done))
    else $error("A pending match coexists with an accepted match.");

  assert property (@(posedge clk) disable iff (rst)
    tok.in_port_part |-> tok.octet_index == ipv4ae_pkg::OCTETS_ALL)
    else $error("Port part is active before all four octets were read.");

  assert property (@(posedge clk) disable iff (rst)
    (in_take && line_end) |=> (out_valid && !match_done && !pending_valid && !tok.in_token))
    else $error("A line end did not produce a result and clear the scan state.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (address == 32'd0 && port == 16'd0 && !has_port))
    else $error("A result without a match carries nonzero fields.");

  assert property (@(posedge clk) disable iff (rst)
    (in_take && !line_end && match_done) |=> (match_done && $stable(match_result)))
    else $error("An accepted match changed before the line ended.");
`endif

endmodule

`default_nettype wire
